// ===== rtl/itb_pkg.sv =====
// Shared types, constants and codes of the implication table builder.
package itb_pkg;

    localparam int NUM_VARS    = 4096;
    localparam int NUM_ENTRIES = 16384;
    localparam int SEC_DEPTH   = NUM_VARS + 1;

    localparam int VAR_W   = 12;
    localparam int SEC_AW  = 13;
    localparam int ENT_AW  = 14;
    localparam int CNT_W   = 15;
    localparam int MAP_W   = 14;
    localparam int ENT_W   = 13;

    // map word: compact index, or one of two negative class marks
    localparam logic [MAP_W-1:0] MAP_CONT = 14'h3FFF;
    localparam logic [MAP_W-1:0] MAP_GEN  = 14'h3FFE;

    localparam logic [1:0] REQ_CLASSIFY = 2'd0;
    localparam logic [1:0] REQ_CLEAR    = 2'd1;
    localparam logic [1:0] REQ_RECORD   = 2'd2;
    localparam logic [1:0] REQ_READ     = 2'd3;

    localparam logic [1:0] CLS_CONT   = 2'd0;
    localparam logic [1:0] CLS_BINARY = 2'd1;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_NONBIN  = 2'd1;
    localparam logic [1:0] STAT_ORDER   = 2'd2;
    localparam logic [1:0] STAT_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] variable;
        logic [1:0]  var_class;
        logic        goes_up;
        logic [11:0] target_variable;
        logic        target_value;
        logic [11:0] read_index;
        logic [13:0] read_position;
    } itb_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] assigned_index;
        logic [14:0] entry_count;
        logic [14:0] down_start;
        logic [14:0] up_start;
        logic [14:0] section_end;
        logic [11:0] entry_target;
        logic        entry_value;
    } itb_rsp_t;

endpackage

// ===== rtl/implication_table_builder.sv =====
// Top level of the implication table builder: request sequencer and state memories.
//
// One request at a time: start is taken while busy is low, and the single
// result appears on rsp for exactly one cycle with done high; the receiver
// cannot hold it off, so capture it then. A record reads the source and
// target map words, fills each skipped section as empty and writes the
// entry; for a down implication it also advances the up boundary and
// moves an existing up entry in that slot to the tail. A record that is
// dropped (non-binary or out of order) ends after the target map read.
// A read fetches the boundary and entry words, then the section end.
// Clear rewrites every boundary word. After reset the block sweeps the
// boundary memories with busy high before it takes its first request.
// Map and entry words are undefined until written.
module implication_table_builder
    import itb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  itb_req_t req,
    output logic     busy,
    output logic     done,
    output itb_rsp_t rsp
);

    localparam logic [3:0] ST_SWEEP   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_REC_SRC = 4'd2;
    localparam logic [3:0] ST_REC_TGT = 4'd3;
    localparam logic [3:0] ST_WALK    = 4'd4;
    localparam logic [3:0] ST_DN_POS  = 4'd5;
    localparam logic [3:0] ST_DN_SWAP = 4'd6;
    localparam logic [3:0] ST_RD1     = 4'd7;
    localparam logic [3:0] ST_RD2     = 4'd8;

    localparam logic [SEC_AW-1:0] SWEEP_LAST = SEC_AW'(SEC_DEPTH - 1);

    logic [3:0]        state_reg, state_next;
    itb_req_t          req_reg, req_next;
    logic [SEC_AW-1:0] sweep_reg, sweep_next;
    logic              sweep_rsp_reg, sweep_rsp_next;
    logic [12:0]       bin_cnt_reg, bin_cnt_next;
    logic [12:0]       last_reg, last_next;   // all ones means minus one
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [MAP_W-1:0]  src_reg, src_next;
    logic [VAR_W-1:0]  fix_reg, fix_next;
    logic [CNT_W-1:0]  down_reg, down_next;
    logic [CNT_W-1:0]  up_reg, up_next;
    logic [ENT_W-1:0]  ent_reg, ent_next;
    logic              done_reg, done_next;
    itb_rsp_t          rsp_reg, rsp_next;

    // memory ports
    logic              map_we;
    logic [VAR_W-1:0]  map_waddr, map_raddr;
    logic [MAP_W-1:0]  map_wdata, map_rdata;
    logic              up_we;
    logic [VAR_W-1:0]  up_waddr, up_raddr;
    logic [CNT_W-1:0]  up_wdata, up_rdata;
    logic              sec_we;
    logic [SEC_AW-1:0] sec_waddr, sec_raddr;
    logic [CNT_W-1:0]  sec_wdata, sec_rdata;
    logic              ent_we;
    logic [ENT_AW-1:0] ent_waddr, ent_raddr;
    logic [ENT_W-1:0]  ent_wdata, ent_rdata;

    logic              accept;
    logic              src_gt_last;
    logic              src_lt_last;
    logic [12:0]       last_inc;
    logic [ENT_W-1:0]  ent_new;
    logic [SEC_AW-1:0] src_sec;

    itb_ram #(.WIDTH(MAP_W), .DEPTH(NUM_VARS)) u_map_ram (
        .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .raddr(map_raddr), .rdata(map_rdata)
    );

    itb_ram #(.WIDTH(CNT_W), .DEPTH(NUM_VARS)) u_up_ram (
        .clk(clk), .we(up_we), .waddr(up_waddr), .wdata(up_wdata),
        .raddr(up_raddr), .rdata(up_rdata)
    );

    itb_ram #(.WIDTH(CNT_W), .DEPTH(SEC_DEPTH)) u_sec_ram (
        .clk(clk), .we(sec_we), .waddr(sec_waddr), .wdata(sec_wdata),
        .raddr(sec_raddr), .rdata(sec_rdata)
    );

    itb_ram #(.WIDTH(ENT_W), .DEPTH(NUM_ENTRIES)) u_ent_ram (
        .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
        .raddr(ent_raddr), .rdata(ent_rdata)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    // compare the source index with last_index, where all ones stands for minus one
    assign src_gt_last = last_reg[12] || ({1'b0, src_reg[VAR_W-1:0]} > last_reg);
    assign src_lt_last = !last_reg[12] && ({1'b0, src_reg[VAR_W-1:0]} < last_reg);
    assign last_inc    = last_reg + 13'd1;
    assign ent_new     = {req_reg.target_value, fix_reg};
    assign src_sec     = {1'b0, src_reg[VAR_W-1:0]} + 13'd1;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        sweep_next     = sweep_reg;
        sweep_rsp_next = sweep_rsp_reg;
        bin_cnt_next   = bin_cnt_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        src_next       = src_reg;
        fix_next       = fix_reg;
        down_next      = down_reg;
        up_next        = up_reg;
        ent_next       = ent_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;

        map_we    = 1'b0;
        map_waddr = '0;
        map_wdata = '0;
        map_raddr = '0;
        up_we     = 1'b0;
        up_waddr  = '0;
        up_wdata  = '0;
        up_raddr  = '0;
        sec_we    = 1'b0;
        sec_waddr = '0;
        sec_wdata = '0;
        sec_raddr = '0;
        ent_we    = 1'b0;
        ent_waddr = '0;
        ent_wdata = '0;
        ent_raddr = '0;

        unique case (state_reg)
            ST_SWEEP:
            begin
                // zero one boundary word of each memory a cycle
                sec_we    = 1'b1;
                sec_waddr = sweep_reg;
                up_we     = !sweep_reg[SEC_AW-1];
                up_waddr  = sweep_reg[VAR_W-1:0];
                if (sweep_reg == SWEEP_LAST)
                begin
                    state_next = ST_IDLE;
                    if (sweep_rsp_reg)
                    begin
                        done_next            = 1'b1;
                        rsp_next             = '0;
                        rsp_next.status      = STAT_DONE;
                        rsp_next.entry_count = count_reg;
                    end
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next = req;
                    unique case (req.req_type)
                        REQ_CLASSIFY:
                        begin
                            map_we               = 1'b1;
                            map_waddr            = req.variable;
                            done_next            = 1'b1;
                            rsp_next             = '0;
                            rsp_next.status      = STAT_DONE;
                            rsp_next.entry_count = count_reg;
                            if (req.var_class == CLS_BINARY)
                            begin
                                if (bin_cnt_reg[12])
                                begin
                                    map_wdata       = MAP_GEN;
                                    rsp_next.status = STAT_FULL;
                                end
                                else
                                begin
                                    map_wdata               = {2'b00, bin_cnt_reg[VAR_W-1:0]};
                                    rsp_next.assigned_index = bin_cnt_reg[VAR_W-1:0];
                                    bin_cnt_next            = bin_cnt_reg + 1'b1;
                                end
                            end
                            else if (req.var_class == CLS_CONT)
                            begin
                                map_wdata = MAP_CONT;
                            end
                            else
                            begin
                                map_wdata = MAP_GEN;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            state_next     = ST_SWEEP;
                            sweep_next     = '0;
                            sweep_rsp_next = 1'b1;
                            last_next      = 13'd0;
                            count_next     = '0;
                        end
                        REQ_RECORD:
                        begin
                            map_raddr  = req.variable;
                            state_next = ST_REC_SRC;
                        end
                        REQ_READ:
                        begin
                            sec_raddr  = {1'b0, req.read_index};
                            up_raddr   = req.read_index;
                            ent_raddr  = req.read_position;
                            state_next = ST_RD1;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_REC_SRC:
            begin
                src_next   = map_rdata;
                map_raddr  = req_reg.target_variable;
                state_next = ST_REC_TGT;
            end

            ST_REC_TGT:
            begin
                fix_next             = map_rdata[VAR_W-1:0];
                rsp_next             = '0;
                rsp_next.entry_count = count_reg;
                if (src_reg[MAP_W-1] || map_rdata[MAP_W-1])
                begin
                    done_next       = 1'b1;
                    rsp_next.status = STAT_NONBIN;
                    state_next      = ST_IDLE;
                end
                else if (src_lt_last)
                begin
                    done_next       = 1'b1;
                    rsp_next.status = STAT_ORDER;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end

            ST_WALK:
            begin
                rsp_next             = '0;
                rsp_next.entry_count = count_reg;
                if (src_gt_last)
                begin
                    // fill one skipped section as empty
                    last_next = last_inc;
                    up_we     = 1'b1;
                    up_waddr  = last_inc[VAR_W-1:0];
                    up_wdata  = count_reg;
                    sec_we    = 1'b1;
                    sec_waddr = last_inc + 13'd1;
                    sec_wdata = count_reg;
                end
                else if (count_reg[CNT_W-1])
                begin
                    done_next       = 1'b1;
                    rsp_next.status = STAT_FULL;
                    state_next      = ST_IDLE;
                end
                else if (req_reg.goes_up)
                begin
                    ent_we               = 1'b1;
                    ent_waddr            = count_reg[ENT_AW-1:0];
                    ent_wdata            = ent_new;
                    sec_we               = 1'b1;
                    sec_waddr            = src_sec;
                    sec_wdata            = count_reg + 1'b1;
                    count_next           = count_reg + 1'b1;
                    done_next            = 1'b1;
                    rsp_next.status      = STAT_DONE;
                    rsp_next.entry_count = count_reg + 1'b1;
                    state_next           = ST_IDLE;
                end
                else
                begin
                    up_raddr   = src_reg[VAR_W-1:0];
                    state_next = ST_DN_POS;
                end
            end

            ST_DN_POS:
            begin
                // advance the up boundary past the new down entry
                up_we    = 1'b1;
                up_waddr = src_reg[VAR_W-1:0];
                up_wdata = up_rdata + 1'b1;
                rsp_next = '0;
                if (up_rdata < count_reg)
                begin
                    // swap: new entry takes the slot, the displaced one moves to the tail
                    ent_raddr  = up_rdata[ENT_AW-1:0];
                    ent_we     = 1'b1;
                    ent_waddr  = up_rdata[ENT_AW-1:0];
                    ent_wdata  = ent_new;
                    state_next = ST_DN_SWAP;
                end
                else
                begin
                    ent_we               = 1'b1;
                    ent_waddr            = count_reg[ENT_AW-1:0];
                    ent_wdata            = ent_new;
                    sec_we               = 1'b1;
                    sec_waddr            = src_sec;
                    sec_wdata            = count_reg + 1'b1;
                    count_next           = count_reg + 1'b1;
                    done_next            = 1'b1;
                    rsp_next.status      = STAT_DONE;
                    rsp_next.entry_count = count_reg + 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            ST_DN_SWAP:
            begin
                ent_we               = 1'b1;
                ent_waddr            = count_reg[ENT_AW-1:0];
                ent_wdata            = ent_rdata;
                sec_we               = 1'b1;
                sec_waddr            = src_sec;
                sec_wdata            = count_reg + 1'b1;
                count_next           = count_reg + 1'b1;
                done_next            = 1'b1;
                rsp_next             = '0;
                rsp_next.status      = STAT_DONE;
                rsp_next.entry_count = count_reg + 1'b1;
                state_next           = ST_IDLE;
            end

            ST_RD1:
            begin
                down_next  = sec_rdata;
                up_next    = up_rdata;
                ent_next   = ent_rdata;
                sec_raddr  = {1'b0, req_reg.read_index} + 13'd1;
                state_next = ST_RD2;
            end

            ST_RD2:
            begin
                done_next             = 1'b1;
                rsp_next              = '0;
                rsp_next.status       = STAT_DONE;
                rsp_next.entry_count  = count_reg;
                rsp_next.down_start   = down_reg;
                rsp_next.up_start     = up_reg;
                rsp_next.section_end  = sec_rdata;
                rsp_next.entry_target = ent_reg[VAR_W-1:0];
                rsp_next.entry_value  = ent_reg[ENT_W-1];
                state_next            = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            req_reg       <= '0;
            sweep_reg     <= '0;
            sweep_rsp_reg <= 1'b0;
            bin_cnt_reg   <= '0;
            last_reg      <= '1;
            count_reg     <= '0;
            src_reg       <= '0;
            fix_reg       <= '0;
            down_reg      <= '0;
            up_reg        <= '0;
            ent_reg       <= '0;
            done_reg      <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            sweep_reg     <= sweep_next;
            sweep_rsp_reg <= sweep_rsp_next;
            bin_cnt_reg   <= bin_cnt_next;
            last_reg      <= last_next;
            count_reg     <= count_next;
            src_reg       <= src_next;
            fix_reg       <= fix_next;
            down_reg      <= down_next;
            up_reg        <= up_next;
            ent_reg       <= ent_next;
            done_reg      <= done_next;
            rsp_reg       <= rsp_next;
        end
    end

    // the entry count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(NUM_ENTRIES))
        else $error("entry count beyond table size");

    // entries are written only inside the filled part of the table or at its tail
    a_ent_write: assert property (@(posedge clk) disable iff (!rst_n)
        ent_we |-> ({1'b0, ent_waddr} <= count_reg) && !count_reg[CNT_W-1])
        else $error("entry write outside filled region");

    // a clear request holds busy and restarts the table at section zero
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.req_type == REQ_CLEAR) |=> busy && last_reg == 13'd0)
        else $error("clear request not taken");

    // the walk never moves last_index past the source index
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DN_POS) |-> !src_gt_last && !src_lt_last)
        else $error("walk overshoot");

endmodule

// ===== rtl/itb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module itb_ram
    import itb_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first: a read and write of one address in a cycle returns the old word
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule
